/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: opcodes,
// status codes, word layouts and the shift control broadcast to the cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int OPC_W        = 3;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;
    localparam int STAT_W       = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_RM_HEAD  = 3'd3,
        OP_RM_TAIL  = 3'd4,
        OP_RM_AT    = 3'd5,
        OP_READ     = 3'd6
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         count;
        logic [STAT_W-1:0]        status;
    } rsp_word_t;

    typedef struct packed {
        logic                     ins;
        logic                     rm;
        logic signed [DATA_W-1:0] value;
    } shift_ctrl_t;

endpackage

/* rtl/ple_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface ple_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/positional_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed 32-bit values held in a row of cells that
// shift in parallel; insert/remove at head, tail or position; read by position
// ----------------------------------------------------------------------------
// response: registered in the cycle after the command word is accepted
// throughput: 1 word per cycle unless rsp stalls; ins/rm shift cells >= index
// reset: count and response valid clear; cell contents are undefined until
// written and are never read beyond the count
// ----------------------------------------------------------------------------
module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic  clk,
    input  logic  rst_n,
    ple_if.sink   cmd,
    ple_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    rsp_word_t                rsp_word_reg;
    rsp_word_t                rsp_word_next;
    logic                     accept;
    logic                     full;
    logic [CMP_W-1:0]         cnt_x;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         idx_x;
    logic signed [DATA_W-1:0] rd_value;
    status_t                  status;
    shift_ctrl_t              ctrl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign cnt_x     = CMP_W'(count_reg);
    assign pos_x     = CMP_W'(cmd.payload.position);

    always_comb
    begin
        ctrl.ins   = 1'b0;
        ctrl.rm    = 1'b0;
        ctrl.value = cmd.payload.value;
        idx_x      = '0;
        count_next = count_reg;
        rd_value   = '0;
        status     = ST_OK;
        case (cmd.payload.opcode)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT:
            begin
                if (cmd.payload.opcode == OP_INS_TAIL)
                begin
                    idx_x = cnt_x;
                end
                else if (cmd.payload.opcode == OP_INS_AT)
                begin
                    idx_x = (pos_x >= cnt_x) ? cnt_x : pos_x;
                end
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.ins   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_RM_HEAD, OP_RM_TAIL, OP_RM_AT:
            begin
                if (cmd.payload.opcode == OP_RM_TAIL)
                begin
                    idx_x = cnt_x - CMP_W'(1);
                end
                else if (cmd.payload.opcode == OP_RM_AT)
                begin
                    if (pos_x <= CMP_W'(1))
                    begin
                        idx_x = '0;
                    end
                    else if (pos_x >= cnt_x)
                    begin
                        idx_x = cnt_x - CMP_W'(1);
                    end
                    else
                    begin
                        idx_x = pos_x - CMP_W'(1);
                    end
                end
                if (count_reg <= CNT_W'(1))
                begin
                    count_next = '0;
                end
                else
                begin
                    ctrl.rm    = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    rd_value = cell_data[pos_x[IDX_W-1:0]];
                end
                else
                begin
                    status = ST_RANGE;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // row of cells, each shifting toward its neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = ctrl.value;
        end
        else
        begin : g_mid_l
            assign left = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right = cell_data[i+1];
        end

        ple_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .idx   (idx_x[IDX_W-1:0]),
            .left  (left),
            .right (right),
            .data  (cell_data[i])
        );
    end

    always_comb
    begin
        rsp_word_next.read_value = rd_value;
        rsp_word_next.count      = POS_W'(count_next);
        rsp_word_next.status     = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_word_reg;

    // count never exceeds the list capacity
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // an accepted insert into a non-full list grows the count by one
    a_ins_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && (cmd.payload.opcode == OP_INS_HEAD
            || cmd.payload.opcode == OP_INS_TAIL
            || cmd.payload.opcode == OP_INS_AT))
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // a dropped insert is only reported with the list at capacity
    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_word_reg.status == ST_FULL)
        |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status with room in the list");

endmodule

/* rtl/ple_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an element and takes the new value, its left
// neighbor or its right neighbor according to the broadcast shift control.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  shift_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == idx)
            begin
                data_next = ctrl.value;
            end
            else if (MY_IDX > idx)
            begin
                data_next = left;
            end
        end
        else if (ctrl.rm)
        begin
            if (MY_IDX >= idx)
            begin
                data_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
